// File: rtl/core/pixel_histogram_binning_defines.svh
// Assertion macros shared by the pixel histogram RTL
`ifndef PIXEL_HISTOGRAM_BINNING_DEFINES_SVH
`define PIXEL_HISTOGRAM_BINNING_DEFINES_SVH
`ifndef SYNTHESIS
// concurrent check, masked while reset is asserted
`define PHB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// concurrent check that also holds during reset
`define PHB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PHB_ASSERT(lbl, prop, msg)
`define PHB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/phb_pkg.sv
// Types and constants of the pixel histogram binning block
`timescale 1ns / 1ps
`default_nettype none

package phb_pkg;

  // saturation ceiling of every count
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  // configuration port width (widest register)
  localparam int unsigned CFG_DATA_W = 9;

  // input operation codes
  typedef enum logic [1:0] {
    MODE_COUNT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_RANGE_LOW     = 2'd0,
    CFG_RANGE_HIGH    = 2'd1,
    CFG_BIN_COUNT     = 2'd2,
    CFG_CHANNEL_COUNT = 2'd3
  } cfg_reg_e;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_RD   = 6'b000100,
    S_UPD  = 6'b001000,
    S_READ = 6'b010000,
    S_CLR  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/pixel_histogram_binning.sv
// A counted sample passes S_DIV, S_RD and S_UPD; a bin read passes S_READ; other items take
// their result straight from S_IDLE. No new item is taken until the last one is done; the bin
// number comes from a restoring divider that retires one quotient bit per cycle, then a
// read-modify-write of the bin memory. Clear mode: result in the cycle after the item is taken,
// then a sweep over all MAX_BINS*MAX_CHANNELS entries (768) during which no item is taken.
// Reset: asynchronous, active low; configuration and control registers return to defaults and
// the same clearing sweep runs before the first item is accepted.
`timescale 1ns / 1ps
`default_nettype none

`include "pixel_histogram_binning_defines.svh"

module pixel_histogram_binning #(
  parameter int unsigned MAX_BINS     = 256,
  parameter int unsigned MAX_CHANNELS = 3
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration write channel
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [1:0]                      cfg_index_i,
  input  wire logic [phb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input item channel
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [1:0]                      mode_i,
  input  wire logic [7:0]                      sample_i,
  input  wire logic [1:0]                      channel_i,
  input  wire logic [7:0]                      bin_index_i,
  // result channel
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [31:0]                          bin_value_o,
  output logic [31:0]                          total_count_o,
  output logic                                 counted_o,
  output logic [7:0]                           bin_hit_o,
  output logic                                 range_error_o
);

  localparam int unsigned DEPTH = MAX_BINS * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned BW    = $clog2(MAX_BINS + 1);
  localparam int unsigned QW    = $clog2(MAX_BINS);
  localparam int unsigned NW    = 8 + BW;
  localparam int unsigned WW    = NW + 1;
  localparam int unsigned CW    = $clog2(QW + 1);

  // configuration registers
  logic [7:0] range_low_q;
  logic [8:0] range_high_q;
  logic [8:0] bin_count_q;
  logic [1:0] channel_count_q;

  // sequencer and datapath registers
  phb_pkg::state_e state_q, state_d;
  logic [AW-1:0]   clr_cnt_q, clr_cnt_d;
  logic [NW-1:0]   rem_q, rem_d;
  logic [WW-1:0]   den_q, den_d;
  logic [QW-1:0]   quot_q, quot_d;
  logic [CW-1:0]   div_cnt_q, div_cnt_d;
  logic [1:0]      chan_q, chan_d;
  logic [AW-1:0]   addr_q, addr_d;
  logic [31:0]     total_q, total_d;
  logic [31:0]     rd_data_q;

  // output register
  logic        out_valid_q, out_valid_d;
  logic [31:0] bin_value_q, bin_value_d;
  logic [31:0] total_out_q, total_out_d;
  logic        counted_q, counted_d;
  logic [7:0]  bin_hit_q, bin_hit_d;
  logic        rerr_out_q, rerr_out_d;

  // bin memory
  logic [31:0]   bin_mem_q [DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  logic          out_free;
  logic          in_fire;
  logic          upd_fire;
  logic [BW-1:0] bins_eff;
  logic [2:0]    chan_lim;
  logic          chan_ok;
  logic          rerr;
  logic          count_ok;
  logic          read_ok;
  logic [7:0]    sample_off;
  logic [8:0]    range_diff;
  logic [NW-1:0] num_in;
  logic [AW-1:0] read_addr;
  logic [AW-1:0] upd_addr;
  logic          div_take;
  logic [31:0]   bin_inc;
  logic [31:0]   total_inc;

  // configuration writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q     <= 8'd0;
      range_high_q    <= 9'd256;
      bin_count_q     <= 9'd256;
      channel_count_q <= 2'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        phb_pkg::CFG_RANGE_LOW:     range_low_q     <= cfg_data_i[7:0];
        phb_pkg::CFG_RANGE_HIGH:    range_high_q    <= cfg_data_i[8:0];
        phb_pkg::CFG_BIN_COUNT:     bin_count_q     <= cfg_data_i[8:0];
        phb_pkg::CFG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // effective bin and channel limits
  always_comb begin
    if (bin_count_q == 9'd0) begin
      bins_eff = BW'(1);
    end else if (32'(bin_count_q) > MAX_BINS) begin
      bins_eff = BW'(MAX_BINS);
    end else begin
      bins_eff = BW'(bin_count_q);
    end
    if (channel_count_q == 2'd0) begin
      chan_lim = 3'd1;
    end else if (32'(channel_count_q) > MAX_CHANNELS) begin
      chan_lim = 3'(MAX_CHANNELS);
    end else begin
      chan_lim = {1'b0, channel_count_q};
    end
  end

  // item qualification and divider operands
  assign chan_ok    = ({1'b0, channel_i} < chan_lim);
  assign rerr       = (range_high_q <= {1'b0, range_low_q});
  assign count_ok   = !rerr && chan_ok && (sample_i >= range_low_q) &&
                      ({1'b0, sample_i} < range_high_q);
  assign read_ok    = chan_ok && ({{(BW > 8 ? BW - 8 : 0){1'b0}}, bin_index_i} < bins_eff);
  assign sample_off = sample_i - range_low_q;
  assign range_diff = range_high_q - {1'b0, range_low_q};
  assign num_in     = {{BW{1'b0}}, sample_off} * {8'd0, bins_eff};
  assign read_addr  = AW'(32'(channel_i) * MAX_BINS + 32'(bin_index_i));
  assign upd_addr   = AW'(32'(chan_q) * MAX_BINS + 32'(quot_q));
  assign div_take   = ({1'b0, rem_q} >= den_q);

  // saturating increments
  assign bin_inc   = (rd_data_q == phb_pkg::COUNT_MAX) ? rd_data_q : rd_data_q + 32'd1;
  assign total_inc = (total_q == phb_pkg::COUNT_MAX) ? total_q : total_q + 32'd1;

  // handshakes
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != phb_pkg::S_IDLE) || !out_free;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign upd_fire   = (state_q == phb_pkg::S_UPD) && out_free;

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    rem_d       = rem_q;
    den_d       = den_q;
    quot_d      = quot_q;
    div_cnt_d   = div_cnt_q;
    chan_d      = chan_q;
    addr_d      = addr_q;
    total_d     = total_q;
    mem_we      = 1'b0;
    mem_waddr   = addr_q;
    mem_wdata   = 32'd0;
    mem_re      = 1'b0;
    mem_raddr   = addr_q;
    out_valid_d = out_free ? 1'b0 : out_valid_q;
    bin_value_d = bin_value_q;
    total_out_d = total_out_q;
    counted_d   = counted_q;
    bin_hit_d   = bin_hit_q;
    rerr_out_d  = rerr_out_q;

    unique case (state_q)
      phb_pkg::S_IDLE: begin
        if (in_fire) begin
          // default result: nothing counted, current total
          bin_value_d = 32'd0;
          total_out_d = total_q;
          counted_d   = 1'b0;
          bin_hit_d   = 8'd0;
          rerr_out_d  = rerr;
          case (mode_i)
            phb_pkg::MODE_COUNT: begin
              if (count_ok) begin
                rem_d     = num_in;
                den_d     = {{(WW - 9){1'b0}}, range_diff} << (QW - 1);
                quot_d    = '0;
                div_cnt_d = CW'(QW - 1);
                chan_d    = channel_i;
                state_d   = phb_pkg::S_DIV;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            phb_pkg::MODE_READ: begin
              if (read_ok) begin
                mem_re    = 1'b1;
                mem_raddr = read_addr;
                state_d   = phb_pkg::S_READ;
              end else begin
                out_valid_d = 1'b1;
              end
            end
            phb_pkg::MODE_CLEAR: begin
              total_d     = 32'd0;
              total_out_d = 32'd0;
              clr_cnt_d   = '0;
              out_valid_d = 1'b1;
              state_d     = phb_pkg::S_CLR;
            end
            default: begin
              out_valid_d = 1'b1;
            end
          endcase
        end
      end
      phb_pkg::S_DIV: begin
        // one restoring quotient bit per cycle
        if (div_take) begin
          rem_d = rem_q - den_q[NW-1:0];
        end
        quot_d = QW'({quot_q, div_take});
        den_d  = den_q >> 1;
        if (div_cnt_q == '0) begin
          state_d = phb_pkg::S_RD;
        end else begin
          div_cnt_d = div_cnt_q - CW'(1);
        end
      end
      phb_pkg::S_RD: begin
        mem_re    = 1'b1;
        mem_raddr = upd_addr;
        addr_d    = upd_addr;
        state_d   = phb_pkg::S_UPD;
      end
      phb_pkg::S_UPD: begin
        // write back the incremented bin once the result slot is free
        if (out_free) begin
          mem_we      = 1'b1;
          mem_waddr   = addr_q;
          mem_wdata   = bin_inc;
          total_d     = total_inc;
          out_valid_d = 1'b1;
          bin_value_d = bin_inc;
          total_out_d = total_inc;
          counted_d   = 1'b1;
          bin_hit_d   = 8'(quot_q);
          rerr_out_d  = rerr;
          state_d     = phb_pkg::S_IDLE;
        end
      end
      phb_pkg::S_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          bin_value_d = rd_data_q;
          total_out_d = total_q;
          counted_d   = 1'b0;
          bin_hit_d   = 8'd0;
          rerr_out_d  = rerr;
          state_d     = phb_pkg::S_IDLE;
        end
      end
      phb_pkg::S_CLR: begin
        // zero one entry per cycle
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = 32'd0;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          state_d = phb_pkg::S_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = phb_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= phb_pkg::S_CLR;
      clr_cnt_q   <= '0;
      div_cnt_q   <= '0;
      total_q     <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      div_cnt_q   <= div_cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath and result payload
  always_ff @(posedge clk_i) begin
    rem_q       <= rem_d;
    den_q       <= den_d;
    quot_q      <= quot_d;
    chan_q      <= chan_d;
    addr_q      <= addr_d;
    bin_value_q <= bin_value_d;
    total_out_q <= total_out_d;
    counted_q   <= counted_d;
    bin_hit_q   <= bin_hit_d;
    rerr_out_q  <= rerr_out_d;
  end

  // bin memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      bin_mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= bin_mem_q[mem_raddr];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bin_value_o   = bin_value_q;
  assign total_count_o = total_out_q;
  assign counted_o     = counted_q;
  assign bin_hit_o     = bin_hit_q;
  assign range_error_o = rerr_out_q;

  // checks
  `PHB_ASSERT_ALWAYS(a_clear_blocks_input, (state_q == phb_pkg::S_CLR) |-> in_stall_o, "item taken during clear")
  `PHB_ASSERT(a_upd_sets_result, upd_fire |=> out_valid_q, "bin update without result transfer")
  `PHB_ASSERT(a_upd_total_nonzero, upd_fire |=> (total_q != 32'd0), "total not advanced by count")
  `PHB_ASSERT(a_bin_in_range, (state_q == phb_pkg::S_RD) |-> (quot_q < bins_eff), "bin beyond bin count")

endmodule

`default_nettype wire

// File: test/pixel_histogram_binning_checker.sv
// Checker for the pixel histogram: tracks configuration, predicts each result and compares it
`timescale 1ns / 1ps

module pixel_histogram_binning_checker #(
  parameter int unsigned MAX_BINS     = 256,
  parameter int unsigned MAX_CHANNELS = 3
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [1:0]                      cfg_index_i,
  input  logic [phb_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  input  logic                            in_stall_i,
  input  logic [1:0]                      mode_i,
  input  logic [7:0]                      sample_i,
  input  logic [1:0]                      channel_i,
  input  logic [7:0]                      bin_index_i,
  input  logic                            out_valid_i,
  input  logic                            out_stall_i,
  input  logic [31:0]                     bin_value_i,
  input  logic [31:0]                     total_count_i,
  input  logic                            counted_i,
  input  logic [7:0]                      bin_hit_i,
  input  logic                            range_error_i,
  output int                              fail_count_o,
  output int                              pending_o
);

  import phb_pkg::*;

  typedef struct packed {
    logic [31:0] bin_value;
    logic [31:0] total_count;
    logic        counted;
    logic [7:0]  bin_hit;
    logic        range_error;
  } hist_result_t;

  // shadow configuration
  logic [7:0] range_low;
  logic [8:0] range_high;
  logic [8:0] bin_count;
  logic [1:0] channel_count;

  // shadow histogram contents
  logic [31:0] bin_store [MAX_BINS*MAX_CHANNELS];
  logic [31:0] sample_total;

  hist_result_t expected_q [$];
  int           fail_count = 0;
  int           pending    = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  // apply one item to the shadow histogram and return the result it must produce
  function automatic hist_result_t histogram_step(mode_e mode, logic [7:0] sample,
                                                  logic [1:0] channel, logic [7:0] bidx);
    hist_result_t r;
    int unsigned  nbins;
    int unsigned  chans;
    int unsigned  bin;
    int unsigned  slot;
    logic         chan_ok;
    r       = '0;
    nbins   = (bin_count == 0) ? 1 : (bin_count > MAX_BINS) ? MAX_BINS : bin_count;
    chans   = (channel_count == 0) ? 1 :
              (channel_count > MAX_CHANNELS) ? MAX_CHANNELS : channel_count;
    chan_ok = (channel < chans);
    r.range_error = (range_high <= range_low);
    case (mode)
      MODE_COUNT: begin
        if (!r.range_error && chan_ok && sample >= range_low && sample < range_high) begin
          bin = ((int'(sample) - int'(range_low)) * nbins) /
                (int'(range_high) - int'(range_low));
          if (bin >= nbins) bin = nbins - 1;
          slot = channel * MAX_BINS + bin;
          if (bin_store[slot] != COUNT_MAX) bin_store[slot] = bin_store[slot] + 1;
          if (sample_total != COUNT_MAX) sample_total = sample_total + 1;
          r.bin_value = bin_store[slot];
          r.counted   = 1'b1;
          r.bin_hit   = bin[7:0];
        end
      end
      MODE_READ: begin
        if (chan_ok && bidx < nbins) r.bin_value = bin_store[channel * MAX_BINS + bidx];
      end
      MODE_CLEAR: begin
        foreach (bin_store[i]) bin_store[i] = '0;
        sample_total = '0;
      end
      default: ;
    endcase
    r.total_count = sample_total;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    hist_result_t want;
    if (!rst_ni) begin
      range_low     = 8'd0;
      range_high    = 9'd256;
      bin_count     = 9'd256;
      channel_count = 2'd1;
      foreach (bin_store[i]) bin_store[i] = '0;
      sample_total  = '0;
      expected_q.delete();
      pending       = 0;
    end else begin
      // register writes are to happen only while the block is idle; the block itself does not enforce it
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_RANGE_LOW:     range_low     = cfg_data_i[7:0];
          CFG_RANGE_HIGH:    range_high    = cfg_data_i[8:0];
          CFG_BIN_COUNT:     bin_count     = cfg_data_i[8:0];
          CFG_CHANNEL_COUNT: channel_count = cfg_data_i[1:0];
          default: ;
        endcase
      end

      // result transfer: compare against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with nothing expected, bin_value %0d total %0d",
                   $time, bin_value_i, total_count_i);
        end else begin
          want = expected_q.pop_front();
          check_field("bin_value", want.bin_value, bin_value_i);
          check_field("total_count", want.total_count, total_count_i);
          check_field("counted", 32'(want.counted), 32'(counted_i));
          check_field("bin_hit", 32'(want.bin_hit), 32'(bin_hit_i));
          check_field("range_error", 32'(want.range_error), 32'(range_error_i));
        end
      end

      // input transfer: predict its result
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(histogram_step(mode_e'(mode_i), sample_i, channel_i,
                                            bin_index_i));
      pending = expected_q.size();
    end
  end

endmodule

// File: test/pixel_histogram_binning_tb.sv
// Testbench top for the pixel histogram: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module pixel_histogram_binning_tb;

  import phb_pkg::*;

  localparam int unsigned MAX_BINS     = 256;
  localparam int unsigned MAX_CHANNELS = 3;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [1:0]             cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [1:0]             mode = '0;
  logic [7:0]             sample = '0;
  logic [1:0]             channel = '0;
  logic [7:0]             bin_index = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [31:0]            bin_value;
  logic [31:0]            total_count;
  logic                   counted;
  logic [7:0]             bin_hit;
  logic                   range_error;
  int                     fail_count;
  int                     pending;

  // current settings, used to steer random items toward the counted range
  logic [7:0] cur_low = 8'd0;
  logic [8:0] cur_high = 9'd256;
  logic [8:0] cur_bins = 9'd256;
  logic [1:0] cur_chans = 2'd1;
  bit         idle_on = 1'b1;
  int         stall_left = 0;

  pixel_histogram_binning #(
    .MAX_BINS    (MAX_BINS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .channel_i    (channel),
    .bin_index_i  (bin_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .bin_value_o  (bin_value),
    .total_count_o(total_count),
    .counted_o    (counted),
    .bin_hit_o    (bin_hit),
    .range_error_o(range_error)
  );

  pixel_histogram_binning_checker #(
    .MAX_BINS    (MAX_BINS),
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .mode_i       (mode),
    .sample_i     (sample),
    .channel_i    (channel),
    .bin_index_i  (bin_index),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .bin_value_i  (bin_value),
    .total_count_i(total_count),
    .counted_i    (counted),
    .bin_hit_i    (bin_hit),
    .range_error_i(range_error),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result side backpressure in random bursts, started only while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 15);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one item transfer; valid stays high afterwards until the next item or a gap
  task automatic send_item(input mode_e m, input logic [7:0] s, input logic [1:0] ch,
                           input logic [7:0] bi);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    sample    <= s;
    channel   <= ch;
    bin_index <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending, let every expected result arrive, then a short settle pause
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write all four registers; unused upper data bits carry random junk
  task automatic program_histogram(input logic [7:0] low, input logic [8:0] high,
                                   input logic [8:0] n_bins, input logic [1:0] chans);
    logic       junk;
    logic [6:0] junk7;
    junk  = $urandom_range(0, 1);
    junk7 = $urandom;
    cfg_write(CFG_RANGE_LOW, {junk, low});
    cfg_write(CFG_RANGE_HIGH, high);
    cfg_write(CFG_BIN_COUNT, n_bins);
    cfg_write(CFG_CHANNEL_COUNT, {junk7, chans});
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_low   = low;
    cur_high  = high;
    cur_bins  = n_bins;
    cur_chans = chans;
  endtask

  // mostly counts in range on live channels, some reads, rare clears and no-ops
  task automatic random_item();
    int unsigned eff_bins;
    int unsigned eff_chans;
    int unsigned hi_sample;
    int          pick;
    mode_e       m;
    logic [7:0]  s;
    logic [1:0]  ch;
    logic [7:0]  bi;
    eff_bins  = (cur_bins == 0) ? 1 : (cur_bins > MAX_BINS) ? MAX_BINS : cur_bins;
    eff_chans = (cur_chans == 0) ? 1 : cur_chans;
    pick = $urandom_range(0, 199);
    m = (pick < 140) ? MODE_COUNT : (pick < 180) ? MODE_READ :
        (pick < 197) ? MODE_NOP : MODE_CLEAR;
    s = $urandom;
    if (cur_low < cur_high && $urandom_range(0, 4) != 0) begin
      hi_sample = (cur_high > 256) ? 255 : cur_high - 1;
      s = $urandom_range(hi_sample, cur_low);
    end
    ch = $urandom_range(0, 3);
    if ($urandom_range(0, 6) != 0) ch = $urandom_range(0, eff_chans - 1);
    bi = $urandom;
    if ($urandom_range(0, 4) != 0) bi = $urandom_range(0, eff_bins - 1);
    send_item(m, s, ch, bi);
  endtask

  task automatic run_phase(input logic [7:0] low, input logic [8:0] high,
                           input logic [8:0] n_bins, input logic [1:0] chans,
                           input int items, input bit idle);
    wait_drained();
    idle_on = idle;
    program_histogram(low, high, n_bins, chans);
    repeat (items) random_item();
  endtask

  // run time limit
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned bn;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: full range, 256 bins, gray only
    send_item(MODE_COUNT, 8'd0, 2'd0, 8'd0);
    send_item(MODE_COUNT, 8'd255, 2'd0, 8'd0);
    send_item(MODE_COUNT, 8'd255, 2'd0, 8'd0);
    send_item(MODE_COUNT, 8'd128, 2'd1, 8'd0);    // channel not in use
    send_item(MODE_COUNT, 8'd7, 2'd3, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd255);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd128);
    send_item(MODE_READ, 8'd0, 2'd2, 8'd0);
    send_item(MODE_NOP, 8'd255, 2'd3, 8'd255);
    send_item(MODE_CLEAR, 8'd0, 2'd0, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd255);

    // empty range flags an error in count, read and no-op items
    wait_drained();
    program_histogram(8'd100, 9'd100, 9'd4, 2'd3);
    send_item(MODE_COUNT, 8'd100, 2'd0, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd0);
    send_item(MODE_NOP, 8'd0, 2'd0, 8'd0);

    // zero bins and zero channels act as one
    wait_drained();
    program_histogram(8'd0, 9'd256, 9'd0, 2'd0);
    send_item(MODE_COUNT, 8'd255, 2'd0, 8'd0);
    send_item(MODE_COUNT, 8'd0, 2'd1, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd0, 8'd1);       // bin index beyond the bin count

    // bin count above the maximum, one-value range at the top, all channels
    wait_drained();
    program_histogram(8'd255, 9'd511, 9'd511, 2'd3);
    send_item(MODE_COUNT, 8'd255, 2'd2, 8'd0);
    send_item(MODE_COUNT, 8'd254, 2'd2, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd2, 8'd0);
    send_item(MODE_READ, 8'd0, 2'd2, 8'd255);

    // fixed settings, extremes first
    run_phase(8'd0, 9'd256, 9'd256, 2'd3, 150, 1'b1);
    run_phase(8'd0, 9'd1, 9'd1, 2'd1, 100, 1'b1);
    run_phase(8'd255, 9'd511, 9'd2, 2'd3, 120, 1'b1);
    run_phase(8'd37, 9'd200, 9'd7, 2'd2, 150, 1'b0);
    run_phase(8'd0, 9'd256, 9'd0, 2'd0, 100, 1'b1);
    run_phase(8'd10, 9'd10, 9'd4, 2'd3, 60, 1'b1);
    run_phase(8'd200, 9'd50, 9'd8, 2'd3, 60, 1'b1);

    // random settings, small bin counts favored so reads hit filled bins
    repeat (7) begin
      lo = $urandom_range(0, 255);
      hi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(lo + 1, 511);
      bn = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 16) : $urandom_range(0, 511);
      run_phase(lo[7:0], hi[8:0], bn[8:0], 2'($urandom_range(0, 3)), 130, 1'b1);
    end

    // closing stretch without any idling
    run_phase(8'd0, 9'd256, 9'd12, 2'd3, 150, 1'b0);

    wait_drained();
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
